// ===== rtl/radius_password_hiding_macros.svh =====
// ----------------------------------------------------------------------------
// radius password hiding assertion macros
// concurrent assertion helpers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef RADIUS_PASSWORD_HIDING_MACROS_SVH
`define RADIUS_PASSWORD_HIDING_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define RPH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rph assertion failed");
// next-cycle implication
`define RPH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rph assertion failed");
`else
`define RPH_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RPH_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/rph_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rph_pkg
// shared types, constants and md5 tables for the password hiding block
// ----------------------------------------------------------------------------
package rph_pkg;

    localparam int MAX_SECRET   = 64;
    localparam int SECRET_AW    = $clog2(MAX_SECRET);
    localparam int SLEN_W       = $clog2(MAX_SECRET + 1);
    localparam int MAX_PASSWORD = 128;
    localparam int PCNT_W       = $clog2(MAX_PASSWORD + 1);

    localparam logic [1:0] REQ_SECRET = 2'd0;
    localparam logic [1:0] REQ_AUTH   = 2'd1;
    localparam logic [1:0] REQ_PASS   = 2'd2;
    localparam logic [1:0] REQ_EMPTY  = 2'd3;

    localparam logic [7:0] MD5_PAD = 8'h80;

    localparam logic [31:0] MD5_IV_A = 32'h67452301;
    localparam logic [31:0] MD5_IV_B = 32'hefcdab89;
    localparam logic [31:0] MD5_IV_C = 32'h98badcfe;
    localparam logic [31:0] MD5_IV_D = 32'h10325476;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } md5_state_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FINAL = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    // message word index used by a round
    function automatic logic [3:0] md5_g(input logic [5:0] idx);
        logic [3:0] i4;
        logic [3:0] g;
        i4 = idx[3:0];
        case (idx[5:4])
            2'd0:    g = i4;
            2'd1:    g = 4'(i4 * 4'd5 + 4'd1);
            2'd2:    g = 4'(i4 * 4'd3 + 4'd5);
            2'd3:    g = 4'(i4 * 4'd7);
            default: g = i4;
        endcase
        return g;
    endfunction

    function automatic logic [4:0] md5_s(input logic [5:0] idx);
        logic [4:0] s;
        case ({idx[5:4], idx[1:0]})
            4'd0:    s = 5'd7;
            4'd1:    s = 5'd12;
            4'd2:    s = 5'd17;
            4'd3:    s = 5'd22;
            4'd4:    s = 5'd5;
            4'd5:    s = 5'd9;
            4'd6:    s = 5'd14;
            4'd7:    s = 5'd20;
            4'd8:    s = 5'd4;
            4'd9:    s = 5'd11;
            4'd10:   s = 5'd16;
            4'd11:   s = 5'd23;
            4'd12:   s = 5'd6;
            4'd13:   s = 5'd10;
            4'd14:   s = 5'd15;
            4'd15:   s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] md5_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'hd76aa478;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/rph_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rph_req_if
// request channel: secret, authenticator and password bytes
// ----------------------------------------------------------------------------
interface rph_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, req_type, data_byte, last, input ready);
    modport sink (input valid, req_type, data_byte, last, output ready);
endinterface

// ===== rtl/rph_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rph_rsp_if
// result channel: hidden bytes with status
// ----------------------------------------------------------------------------
interface rph_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] hidden_byte;
    logic       status;
    logic       last_of_run;

    modport source (output valid, hidden_byte, status, last_of_run, input ready);
    modport sink (input valid, hidden_byte, status, last_of_run, output ready);
endinterface

// ===== rtl/rph_md5_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rph_md5_round
// one md5 round step, shared over all 64 rounds of a block
// ----------------------------------------------------------------------------
module rph_md5_round (
    input  rph_pkg::md5_state_t st_in,
    input  logic [31:0]         msg_word,
    input  logic [5:0]          rnd,
    output rph_pkg::md5_state_t st_out
);

    logic [31:0] f;
    logic [31:0] sum;
    logic [4:0]  sh;
    logic [63:0] dbl;

    always_comb
    begin
        case (rnd[5:4])
            2'd0:    f = (st_in.b & st_in.c) | (~st_in.b & st_in.d);
            2'd1:    f = (st_in.b & st_in.d) | (st_in.c & ~st_in.d);
            2'd2:    f = st_in.b ^ st_in.c ^ st_in.d;
            2'd3:    f = st_in.c ^ (st_in.b | ~st_in.d);
            default: f = st_in.b ^ st_in.c ^ st_in.d;
        endcase
    end

    assign sum = st_in.a + f + rph_pkg::md5_k(rnd) + msg_word;
    assign sh  = rph_pkg::md5_s(rnd);
    // rotate left: upper half of the doubled word shifted
    assign dbl = {sum, sum} << sh;

    assign st_out.a = st_in.d;
    assign st_out.b = st_in.b + dbl[63:32];
    assign st_out.c = st_in.b;
    assign st_out.d = st_in.c;

endmodule

// ===== rtl/radius_password_hiding.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radius_password_hiding
// hides a radius user-password with md5 over secret plus authenticator or
// the previous hidden block, one md5 round per cycle
// ----------------------------------------------------------------------------
//
// channel | dir | payload                              | handshake
// --------+-----+--------------------------------------+-----------
// req     | in  | req_type, data_byte, last            | valid/ready
// rsp     | out | hidden_byte, status, last_of_run     | valid/ready
//
// secret and authenticator requests give no result
// a password byte at a block start, or an empty password, runs one md5:
// per 64-byte block a message load, the rounds and one chain add,
// one block for secrets up to 39 bytes and two above that
// each result then passes through the output register; the round unit
// is the single busy resource, and req is not ready until emission ends
// reset clears sequencer and counters; emit regs, stores unknown until written
// a stalled rsp holds the sequencer in the emit phase, req waits meanwhile

`include "radius_password_hiding_macros.svh"

module radius_password_hiding (
    input  logic      clk,
    input  logic      rst_n,
    rph_req_if.sink   req,
    rph_rsp_if.source rsp
);

    rph_pkg::state_t state_reg;
    rph_pkg::state_t state_next;

    // secret storage
    logic [7:0]                   secret_mem [rph_pkg::MAX_SECRET];
    logic [7:0]                   mem_rd_reg;
    logic [rph_pkg::SLEN_W-1:0]   sec_count_reg;
    logic                         secret_done_reg;

    // authenticator, hidden block and password position
    logic [7:0]                   auth_reg [16];
    logic [3:0]                   auth_cnt_reg;
    logic [7:0]                   hidden_reg [16];
    logic [rph_pkg::PCNT_W-1:0]   pcnt_reg;

    // md5 datapath
    logic [31:0]                  chain_reg [4];
    rph_pkg::md5_state_t          abcd_reg;
    rph_pkg::md5_state_t          round_out;
    logic [31:0]                  msg_reg [16];
    logic [5:0]                   rnd_reg;
    logic                         blk_reg;
    logic                         tail_auth_reg;

    // message load pipeline
    logic [6:0]                   lcnt_reg;
    logic                         ld_v_reg;
    logic                         ld_mem_reg;
    logic [7:0]                   ld_byte_reg;
    logic [5:0]                   ld_idx_reg;

    // emission control
    logic [3:0]                   e_pos_reg;
    logic                         e_first_reg;
    logic                         e_pad_reg;
    logic                         e_drop_reg;
    logic [7:0]                   pw_byte_reg;

    // output register
    logic                         o_valid_reg;
    logic [7:0]                   o_byte_reg;
    logic                         o_status_reg;
    logic                         o_last_reg;

    logic                         req_fire;
    logic [rph_pkg::SLEN_W-1:0]   eff_len;
    logic                         secret_wr;
    logic                         fresh_digest;

    logic [6:0]                   msg_pos;
    logic [6:0]                   total;
    logic                         last_blk;
    logic [9:0]                   bit_len;
    logic [6:0]                   len_pos;
    logic [6:0]                   tail_diff;
    logic [7:0]                   tail_byte;
    logic                         src_mem;
    logic [7:0]                   src_byte;

    logic [31:0]                  dig_word;
    logic [7:0]                   dig_byte;
    logic [7:0]                   emit_byte;
    logic                         emit_load;
    logic                         emit_done;
    logic                         round_last;

    assign req.ready = (state_reg == rph_pkg::ST_IDLE);
    assign req_fire  = req.valid && req.ready;

    assign rsp.valid       = o_valid_reg;
    assign rsp.hidden_byte = o_byte_reg;
    assign rsp.status      = o_status_reg;
    assign rsp.last_of_run = o_last_reg;

    // a secret byte after a finished secret restarts it
    assign eff_len   = secret_done_reg ? '0 : sec_count_reg;
    assign secret_wr = eff_len < rph_pkg::SLEN_W'(rph_pkg::MAX_SECRET);

    // empty password or a password byte at a block start hashes from scratch
    assign fresh_digest = (req.req_type == rph_pkg::REQ_EMPTY) ||
                          ((req.req_type == rph_pkg::REQ_PASS) &&
                           !pcnt_reg[rph_pkg::PCNT_W-1] && (pcnt_reg[3:0] == 4'd0));

    // message byte source for the current load position
    assign msg_pos   = {blk_reg, lcnt_reg[5:0]};
    assign total     = 7'(sec_count_reg) + 7'd16;
    assign last_blk  = (total + 7'd8) >= 7'd64;
    assign bit_len   = {total, 3'b000};
    assign len_pos   = last_blk ? 7'd120 : 7'd56;
    assign tail_diff = msg_pos - 7'(sec_count_reg);
    assign tail_byte = tail_auth_reg ? auth_reg[tail_diff[3:0]]
                                     : hidden_reg[tail_diff[3:0]];

    always_comb
    begin
        src_mem  = 1'b0;
        src_byte = 8'h00;
        if (msg_pos < 7'(sec_count_reg))
        begin
            src_mem = 1'b1;
        end
        else if (msg_pos < total)
        begin
            src_byte = tail_byte;
        end
        else if (msg_pos == total)
        begin
            src_byte = rph_pkg::MD5_PAD;
        end
        else if (msg_pos == len_pos)
        begin
            src_byte = bit_len[7:0];
        end
        else if (msg_pos == len_pos + 7'd1)
        begin
            src_byte = {6'b000000, bit_len[9:8]};
        end
    end

    rph_md5_round u_round (
        .st_in    (abcd_reg),
        .msg_word (msg_reg[rph_pkg::md5_g(rnd_reg)]),
        .rnd      (rnd_reg),
        .st_out   (round_out)
    );

    // digest byte at the emit position, little-endian within each word
    assign dig_word  = chain_reg[e_pos_reg[3:2]];
    assign dig_byte  = dig_word[8*e_pos_reg[1:0] +: 8];
    assign emit_byte = e_drop_reg ? 8'h00
                                  : (e_first_reg ? (pw_byte_reg ^ dig_byte) : dig_byte);
    assign emit_load = (state_reg == rph_pkg::ST_EMIT) && (!o_valid_reg || rsp.ready);
    assign emit_done = e_drop_reg || !e_pad_reg || (e_pos_reg == 4'd15);
    assign round_last = (state_reg == rph_pkg::ST_ROUND) && (rnd_reg == 6'd63);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rph_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.req_type == rph_pkg::REQ_EMPTY)
                    begin
                        state_next = rph_pkg::ST_LOAD;
                    end
                    else if (req.req_type == rph_pkg::REQ_PASS)
                    begin
                        if (!pcnt_reg[rph_pkg::PCNT_W-1] && (pcnt_reg[3:0] == 4'd0))
                        begin
                            state_next = rph_pkg::ST_LOAD;
                        end
                        else
                        begin
                            state_next = rph_pkg::ST_EMIT;
                        end
                    end
                end
            end
            rph_pkg::ST_LOAD:
            begin
                if (lcnt_reg == 7'd64)
                begin
                    state_next = rph_pkg::ST_ROUND;
                end
            end
            rph_pkg::ST_ROUND:
            begin
                if (rnd_reg == 6'd63)
                begin
                    state_next = rph_pkg::ST_FINAL;
                end
            end
            rph_pkg::ST_FINAL:
            begin
                state_next = (blk_reg == last_blk) ? rph_pkg::ST_EMIT : rph_pkg::ST_LOAD;
            end
            rph_pkg::ST_EMIT:
            begin
                if (emit_load && emit_done)
                begin
                    state_next = rph_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rph_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= rph_pkg::ST_IDLE;
            sec_count_reg   <= '0;
            secret_done_reg <= 1'b0;
            auth_cnt_reg    <= 4'd0;
            pcnt_reg        <= '0;
            lcnt_reg        <= 7'd0;
            ld_v_reg        <= 1'b0;
            rnd_reg         <= 6'd0;
            blk_reg         <= 1'b0;
            o_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // output register fills on an emit, drains on an accepted result
            if (emit_load)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (o_valid_reg && rsp.ready)
            begin
                o_valid_reg <= 1'b0;
            end
            case (state_reg)
                rph_pkg::ST_IDLE:
                begin
                    blk_reg  <= 1'b0;
                    lcnt_reg <= 7'd0;
                    ld_v_reg <= 1'b0;
                    if (req_fire)
                    begin
                        case (req.req_type)
                            rph_pkg::REQ_SECRET:
                            begin
                                sec_count_reg   <= eff_len + rph_pkg::SLEN_W'(secret_wr);
                                secret_done_reg <= req.last;
                            end
                            rph_pkg::REQ_AUTH:
                            begin
                                auth_cnt_reg <= auth_cnt_reg + 4'd1;
                            end
                            rph_pkg::REQ_EMPTY:
                            begin
                                pcnt_reg <= '0;
                            end
                            rph_pkg::REQ_PASS:
                            begin
                                if (pcnt_reg[rph_pkg::PCNT_W-1])
                                begin
                                    if (req.last)
                                    begin
                                        pcnt_reg <= '0;
                                    end
                                end
                                else
                                begin
                                    pcnt_reg <= req.last ? '0 : pcnt_reg + 1'b1;
                                end
                            end
                            default:
                            begin
                                pcnt_reg <= pcnt_reg;
                            end
                        endcase
                    end
                end
                rph_pkg::ST_LOAD:
                begin
                    if (lcnt_reg == 7'd64)
                    begin
                        ld_v_reg <= 1'b0;
                        rnd_reg  <= 6'd0;
                    end
                    else
                    begin
                        ld_v_reg <= 1'b1;
                        lcnt_reg <= lcnt_reg + 7'd1;
                    end
                end
                rph_pkg::ST_ROUND:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                end
                rph_pkg::ST_FINAL:
                begin
                    // second block of a long message
                    blk_reg  <= 1'b1;
                    lcnt_reg <= 7'd0;
                    ld_v_reg <= 1'b0;
                end
                default:
                begin
                    ld_v_reg <= 1'b0;
                end
            endcase
        end
    end

    // secret memory with registered read
    always_ff @(posedge clk)
    begin
        if (req_fire && (req.req_type == rph_pkg::REQ_SECRET) && secret_wr)
        begin
            secret_mem[eff_len[rph_pkg::SECRET_AW-1:0]] <= req.data_byte;
        end
        mem_rd_reg <= secret_mem[msg_pos[rph_pkg::SECRET_AW-1:0]];
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            if (req.req_type == rph_pkg::REQ_AUTH)
            begin
                auth_reg[auth_cnt_reg] <= req.data_byte;
            end
            if (req.req_type == rph_pkg::REQ_EMPTY)
            begin
                tail_auth_reg <= 1'b1;
                e_pos_reg     <= 4'd0;
                e_first_reg   <= 1'b0;
                e_pad_reg     <= 1'b1;
                e_drop_reg    <= 1'b0;
            end
            if (req.req_type == rph_pkg::REQ_PASS)
            begin
                tail_auth_reg <= (pcnt_reg == '0);
                e_pos_reg     <= pcnt_reg[3:0];
                e_first_reg   <= 1'b1;
                e_drop_reg    <= pcnt_reg[rph_pkg::PCNT_W-1];
                e_pad_reg     <= req.last ||
                                 (pcnt_reg == rph_pkg::PCNT_W'(rph_pkg::MAX_PASSWORD - 1));
                pw_byte_reg   <= req.data_byte;
            end
            // a fresh digest always starts from the initial chain
            if (fresh_digest)
            begin
                chain_reg[0] <= rph_pkg::MD5_IV_A;
                chain_reg[1] <= rph_pkg::MD5_IV_B;
                chain_reg[2] <= rph_pkg::MD5_IV_C;
                chain_reg[3] <= rph_pkg::MD5_IV_D;
            end
        end

        if (state_reg == rph_pkg::ST_LOAD)
        begin
            ld_mem_reg  <= src_mem;
            ld_byte_reg <= src_byte;
            ld_idx_reg  <= lcnt_reg[5:0];
            if (ld_v_reg)
            begin
                msg_reg[ld_idx_reg[5:2]][8*ld_idx_reg[1:0] +: 8] <=
                    ld_mem_reg ? mem_rd_reg : ld_byte_reg;
            end
            if (lcnt_reg == 7'd64)
            begin
                abcd_reg <= '{a: chain_reg[0], b: chain_reg[1],
                              c: chain_reg[2], d: chain_reg[3]};
            end
        end

        if (state_reg == rph_pkg::ST_ROUND)
        begin
            abcd_reg <= round_out;
        end

        if (state_reg == rph_pkg::ST_FINAL)
        begin
            chain_reg[0] <= chain_reg[0] + abcd_reg.a;
            chain_reg[1] <= chain_reg[1] + abcd_reg.b;
            chain_reg[2] <= chain_reg[2] + abcd_reg.c;
            chain_reg[3] <= chain_reg[3] + abcd_reg.d;
        end

        if (emit_load)
        begin
            o_byte_reg   <= emit_byte;
            o_status_reg <= e_drop_reg;
            o_last_reg   <= !e_drop_reg && e_pad_reg && (e_pos_reg == 4'd15);
            if (!e_drop_reg)
            begin
                hidden_reg[e_pos_reg] <= emit_byte;
            end
            if (!emit_done)
            begin
                e_pos_reg   <= e_pos_reg + 4'd1;
                e_first_reg <= 1'b0;
            end
        end
    end

    // 64 rounds always end in the chain add
    `RPH_ASSERT_NXT(a_round_end, clk, rst_n, round_last, state_reg == rph_pkg::ST_FINAL)
    // a dropped byte never closes the attribute value
    `RPH_ASSERT_IMP(a_drop_not_last, clk, rst_n, o_valid_reg && o_status_reg, !o_last_reg)
    // load counter stays inside one block
    `RPH_ASSERT_IMP(a_load_bound, clk, rst_n, state_reg == rph_pkg::ST_LOAD, lcnt_reg <= 7'd64)

endmodule

// ===== test/radius_password_hiding_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radius_password_hiding_tb
// drives secret, authenticator and password requests into the hiding block
// with random idle gaps and result stalls, predicts every hidden byte with a
// behavioral md5 and compares all results in order
// ----------------------------------------------------------------------------
module radius_password_hiding_tb;

    typedef struct {
        logic [7:0] hidden_byte;
        logic       status;
        logic       last_of_run;
    } hidden_t;

    // predictor of the hiding block plus the queue of expected results
    class hiding_scoreboard;
        logic [7:0]  secret_mem[rph_pkg::MAX_SECRET];
        int          sec_count;
        bit          secret_closed;
        logic [7:0]  auth_mem[16];
        int          auth_pos;
        logic [7:0]  digest[16];
        logic [7:0]  prev_block[16];
        int          pass_count;
        logic [31:0] chain[4];
        logic [31:0] sine_tab[64];
        int          rot_tab[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
        hidden_t     expected_bytes[$];
        int          mismatches;
        int          checked;
        int          dropped;
        int          empties;
        int          password_ends;

        function new();
            for (int i = 0; i < 64; i++)
                sine_tab[i] = 32'(longint'($floor($sqrt($sin(i + 1.0) ** 2) * 4294967296.0)));
            sec_count     = 0;
            secret_closed = 0;
            auth_pos      = 0;
            pass_count    = 0;
            mismatches    = 0;
            checked       = 0;
        endfunction

        function void add_result(logic [7:0] hb, logic st, logic lr);
            hidden_t r;
            r.hidden_byte = hb;
            r.status      = st;
            r.last_of_run = lr;
            expected_bytes.push_back(r);
        endfunction

        // digest = md5(secret + 16-byte tail), padded with bit length
        function void hash_with(logic [7:0] tail[16]);
            logic [7:0]  msg[128];
            logic [31:0] m[16];
            logic [31:0] a, b, c, d, f, t;
            logic [63:0] bits;
            int          total, nblk, g;
            foreach (msg[i]) msg[i] = 8'h00;
            for (int i = 0; i < sec_count; i++) msg[i] = secret_mem[i];
            for (int i = 0; i < 16; i++) msg[sec_count + i] = tail[i];
            total = sec_count + 16;
            nblk  = (total + 8) / 64 + 1;
            msg[total] = rph_pkg::MD5_PAD;
            bits = 64'(total) * 8;
            for (int i = 0; i < 8; i++) msg[nblk * 64 - 8 + i] = bits[8 * i +: 8];
            chain = '{rph_pkg::MD5_IV_A, rph_pkg::MD5_IV_B, rph_pkg::MD5_IV_C,
                      rph_pkg::MD5_IV_D};
            for (int blk = 0; blk < nblk; blk++)
            begin
                for (int i = 0; i < 16; i++)
                    m[i] = {msg[blk * 64 + 4 * i + 3], msg[blk * 64 + 4 * i + 2],
                            msg[blk * 64 + 4 * i + 1], msg[blk * 64 + 4 * i]};
                a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
                for (int i = 0; i < 64; i++)
                begin
                    if (i < 16)      begin f = (b & c) | (~b & d); g = i; end
                    else if (i < 32) begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
                    else if (i < 48) begin f = b ^ c ^ d;          g = (3 * i + 5) % 16; end
                    else             begin f = c ^ (b | ~d);       g = (7 * i) % 16; end
                    t = a + f + sine_tab[i] + m[g];
                    t = (t << rot_tab[(i / 16) * 4 + i % 4]) |
                        (t >> (32 - rot_tab[(i / 16) * 4 + i % 4]));
                    a = d; d = c; c = b; b = b + t;
                end
                chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
            end
            for (int i = 0; i < 16; i++) digest[i] = chain[i / 4][8 * (i % 4) +: 8];
        endfunction

        function void note_request(logic [1:0] kind, logic [7:0] data, logic last);
            int         pos;
            logic [7:0] h;
            case (kind)
                rph_pkg::REQ_SECRET:
                begin
                    if (secret_closed)
                    begin
                        secret_closed = 0;
                        sec_count     = 0;
                    end
                    if (sec_count < rph_pkg::MAX_SECRET) secret_mem[sec_count++] = data;
                    if (last) secret_closed = 1;
                end
                rph_pkg::REQ_AUTH:
                begin
                    auth_mem[auth_pos] = data;
                    auth_pos = (auth_pos + 1) % 16;
                end
                rph_pkg::REQ_EMPTY:
                begin
                    empties++;
                    pass_count = 0;
                    hash_with(auth_mem);
                    for (int i = 0; i < 16; i++)
                    begin
                        prev_block[i] = digest[i];
                        add_result(digest[i], 1'b0, i == 15);
                    end
                end
                default:
                begin
                    if (pass_count >= rph_pkg::MAX_PASSWORD)
                    begin
                        dropped++;
                        add_result(8'h00, 1'b1, 1'b0);
                        if (last) pass_count = 0;
                    end
                    else
                    begin
                        pos = pass_count % 16;
                        if (pos == 0) hash_with(pass_count == 0 ? auth_mem : prev_block);
                        h = data ^ digest[pos];
                        prev_block[pos] = h;
                        pass_count++;
                        if (!last && pass_count < rph_pkg::MAX_PASSWORD)
                            add_result(h, 1'b0, 1'b0);
                        else
                        begin
                            // value ends here: zero pad to the block end
                            password_ends++;
                            add_result(h, 1'b0, pos == 15);
                            for (int i = pos + 1; i < 16; i++)
                            begin
                                prev_block[i] = digest[i];
                                add_result(digest[i], 1'b0, i == 15);
                            end
                            if (last) pass_count = 0;
                        end
                    end
                end
            endcase
        endfunction

        function void check_result(logic [7:0] hb, logic st, logic lr);
            hidden_t e;
            checked++;
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result hidden=%h status=%b last=%b",
                             $realtime, hb, st, lr);
                return;
            end
            e = expected_bytes.pop_front();
            if (hb !== e.hidden_byte || st !== e.status || lr !== e.last_of_run)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result %0d expected hidden=%h status=%b last=%b, got %h %b %b",
                             $realtime, checked, e.hidden_byte, e.status, e.last_of_run,
                             hb, st, lr);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    rph_req_if req_ch();
    rph_rsp_if rsp_ch();

    radius_password_hiding u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    hiding_scoreboard sb = new();
    int  requests_sent = 0;
    bit  no_idle = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one; none during quiet stretches
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one request: hold valid until accepted, then maybe idle
    task automatic push_request(logic [1:0] kind, logic [7:0] data, logic last);
        int g;
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= kind;
        req_ch.data_byte <= data;
        req_ch.last      <= last;
        do @(posedge clk); while (!req_ch.ready);
        sb.note_request(kind, data, last);
        requests_sent++;
        g = pick_gap();
        if (g > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic push_secret(int len);
        for (int i = 0; i < len; i++)
            push_request(rph_pkg::REQ_SECRET, 8'($urandom), i == len - 1);
    endtask

    // password of len bytes; the last one carries the end mark if asked
    task automatic push_password(int len, bit mark_end);
        for (int i = 0; i < len; i++)
            push_request(rph_pkg::REQ_PASS, 8'($urandom), mark_end && i == len - 1);
    endtask

    // result side: random stalls of ready
    initial
    begin
        int g;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            g = pick_gap();
            if (g > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    // every accepted result goes to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.hidden_byte, rsp_ch.status, rsp_ch.last_of_run);
    end

    initial
    begin
        int r;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= rph_pkg::REQ_SECRET;
        req_ch.data_byte <= 8'h00;
        req_ch.last      <= 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: whole authenticator first so no unwritten byte is hashed
        push_request(rph_pkg::REQ_AUTH, 8'h00, 1'b0);
        push_request(rph_pkg::REQ_AUTH, 8'hff, 1'b1);
        for (int i = 2; i < 16; i++) push_request(rph_pkg::REQ_AUTH, 8'($urandom), 1'b0);
        // password before any secret, then a one-byte secret
        push_request(rph_pkg::REQ_PASS, 8'hff, 1'b1);
        push_request(rph_pkg::REQ_SECRET, 8'hff, 1'b1);
        push_request(rph_pkg::REQ_EMPTY, 8'h00, 1'b0);
        push_request(rph_pkg::REQ_PASS, 8'h00, 1'b1);
        // exactly one full block, so the end mark lands on the block end
        push_password(16, 1'b1);
        push_password(17, 1'b1);

        // random: well-formed sequences with random content plus some noise
        while (requests_sent < 470)
        begin
            no_idle = ($urandom_range(0, 5) == 0);
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                // secrets around the one/two block boundary and past the store
                if ($urandom_range(0, 4) == 0) push_secret($urandom_range(36, 70));
                else push_secret($urandom_range(1, 12));
            end
            else if (r < 20)
            begin
                repeat ($urandom_range(1, 18))
                    push_request(rph_pkg::REQ_AUTH, 8'($urandom), 1'($urandom));
            end
            else if (r < 30)
                push_request(rph_pkg::REQ_EMPTY, 8'($urandom), 1'($urandom));
            else if (r < 80)
                push_password($urandom_range(1, 35), 1'b1);
            else if (r < 84)
                // fills the buffer, then dropped bytes until the end mark
                push_password($urandom_range(128, 133), 1'b1);
            else if (r < 90)
                // broken sequence: password with no end mark
                push_password($urandom_range(1, 20), 1'b0);
            else
                push_request(2'($urandom), 8'($urandom), 1'($urandom));
        end
        req_ch.valid <= 1'b0;
        no_idle = 0;

        while (sb.expected_bytes.size() > 0) @(posedge clk);
        repeat (400) @(posedge clk);

        $display("covered %0d requests, %0d results: %0d password ends, %0d empty, %0d dropped",
                 requests_sent, sb.checked, sb.password_ends, sb.empties, sb.dropped);
        $display("mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_bytes.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #40ms;
        $display("timeout with %0d results outstanding", sb.expected_bytes.size());
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
